[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, held off during reset
`define TSQM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsqm assertion failed");

// next-cycle implication, sampled on clk, held off during reset
`define TSQM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsqm assertion failed");

`else

`define TSQM_ASSERT_IMP(lbl, ante, cons)
`define TSQM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/tsqm_pkg.sv]
// types and constants for the timestamp ordered queue merge
`default_nettype none

package tsqm_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int TAG_WIDTH   = 32;
  localparam int NUM_Q       = 3;
  localparam int PTS_W       = 64;
  localparam int FRAME_TAG_W = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W       = 8;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;

  localparam ptr_t PTR_LAST  = ptr_t'(QUEUE_DEPTH - 1);
  localparam cnt_t CNT_FULL  = cnt_t'(QUEUE_DEPTH);
  localparam logic [CFG_W-1:0] VIDEO_LIMIT_RESET = 8'd200;

  typedef struct packed {
    logic [PTS_W-1:0] pts;
    tag_t             tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MEDIA_VIDEO = 2'd0,
    MEDIA_AUDIO = 2'd1,
    MEDIA_META  = 2'd2,
    MEDIA_OTHER = 2'd3
  } media_t;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_VIDEO_EN    = 2'd0,
    CFG_AUDIO_EN    = 2'd1,
    CFG_META_EN     = 2'd2,
    CFG_VIDEO_LIMIT = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/tsqm_ram.sv]
// simple dual port ram with registered read data
`default_nettype none

module tsqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/tsqm_ctrl.sv]
// controller: accept and execute sequencing
`default_nettype none
`include "assert_macros.svh"

module tsqm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire tsqm_pkg::dp_stat_t   stat,
  output      tsqm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready   = in_ready_r;
  assign cmd.load   = in_valid && in_ready_r;
  assign cmd.commit = (state_r == S_EXEC) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  `TSQM_ASSERT_IMP(a_ready_idle, in_ready_r, state_r == S_IDLE)
  `TSQM_ASSERT_NXT(a_load_exec, cmd.load, (state_r == S_EXEC) && !in_ready_r)
  `TSQM_ASSERT_NXT(a_commit_idle, cmd.commit, (state_r == S_IDLE) && in_ready_r)

endmodule

`default_nettype wire

[rtl/tsqm_dp.sv]
// datapath: config, queues, front compare and result register
`default_nettype none
`include "assert_macros.svh"

module tsqm_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tsqm_pkg::ctrl_cmd_t                   cmd,
  output      tsqm_pkg::dp_stat_t                    stat,
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [tsqm_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                  in_kind,
  input  wire logic [1:0]                            in_media_type,
  input  wire logic signed [tsqm_pkg::PTS_W-1:0]     in_pts,
  input  wire logic [tsqm_pkg::FRAME_TAG_W-1:0]      in_frame_tag,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [2:0]                            out_status,
  output      logic [1:0]                            out_media,
  output      logic signed [tsqm_pkg::PTS_W-1:0]     out_pts,
  output      logic [tsqm_pkg::FRAME_TAG_W-1:0]      out_tag
);

  // config registers
  logic                         video_en_r;
  logic                         audio_en_r;
  logic                         meta_en_r;
  logic [tsqm_pkg::CFG_W-1:0]   video_limit_r;

  // held transaction
  tsqm_pkg::kind_t              kind_r;
  tsqm_pkg::media_t             media_r;
  logic [tsqm_pkg::PTS_W-1:0]   pts_r;
  tsqm_pkg::tag_t               tag_r;

  // queue bookkeeping
  tsqm_pkg::ptr_t               rd_ptr_r [tsqm_pkg::NUM_Q];
  tsqm_pkg::ptr_t               wr_ptr_r [tsqm_pkg::NUM_Q];
  tsqm_pkg::cnt_t               cnt_r    [tsqm_pkg::NUM_Q];

  // result register
  logic                         out_valid_r;
  tsqm_pkg::status_t            out_status_r;
  logic [1:0]                   out_media_r;
  logic [tsqm_pkg::PTS_W-1:0]   out_pts_r;
  logic [tsqm_pkg::FRAME_TAG_W-1:0] out_tag_r;

  tsqm_pkg::entry_t             rdata  [tsqm_pkg::NUM_Q];
  tsqm_pkg::entry_t             wdata;
  logic                         ram_we [tsqm_pkg::NUM_Q];
  logic                         nonempty [tsqm_pkg::NUM_Q];
  logic                         win    [tsqm_pkg::NUM_Q];

  logic                         enabled;
  logic                         full_sel;
  logic                         video_over;
  tsqm_pkg::status_t            enq_status;
  logic                         lt10;
  logic                         lt20;
  logic                         lt21;
  logic                         any_ne;
  logic [1:0]                   best_q;
  tsqm_pkg::entry_t             best_entry;
  logic                         deq_commit;
  logic                         do_push;
  logic                         do_pop;

  assign wdata.pts = pts_r;
  assign wdata.tag = tag_r;

  for (genvar q = 0; q < tsqm_pkg::NUM_Q; q++) begin : g_q
    assign ram_we[q]   = do_push && (media_r == tsqm_pkg::media_t'(q));
    assign nonempty[q] = (cnt_r[q] != '0);

    tsqm_ram #(
      .WIDTH (tsqm_pkg::ENTRY_W),
      .DEPTH (tsqm_pkg::QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[q]),
      .waddr (wr_ptr_r[q]),
      .wdata (wdata),
      .raddr (rd_ptr_r[q]),
      .rdata (rdata[q])
    );
  end

  // enqueue decision
  always_comb begin
    enabled  = 1'b0;
    full_sel = 1'b0;
    case (media_r)
      tsqm_pkg::MEDIA_VIDEO: begin
        enabled  = video_en_r;
        full_sel = (cnt_r[0] >= tsqm_pkg::CNT_FULL);
      end
      tsqm_pkg::MEDIA_AUDIO: begin
        enabled  = audio_en_r;
        full_sel = (cnt_r[1] >= tsqm_pkg::CNT_FULL);
      end
      tsqm_pkg::MEDIA_META: begin
        enabled  = meta_en_r;
        full_sel = (cnt_r[2] >= tsqm_pkg::CNT_FULL);
      end
      default: begin
        enabled  = 1'b0;
        full_sel = 1'b0;
      end
    endcase
    video_over = (media_r == tsqm_pkg::MEDIA_VIDEO) &&
                 (32'(cnt_r[0]) > 32'(video_limit_r));
    if (!enabled) begin
      enq_status = tsqm_pkg::ST_IGNORED;
    end else if (full_sel || video_over) begin
      enq_status = tsqm_pkg::ST_OVERFLOW;
    end else begin
      enq_status = tsqm_pkg::ST_ACCEPTED;
    end
  end

  // front compare, strict less-than keeps the video, audio, meta priority on ties
  always_comb begin
    lt10 = $signed(rdata[1].pts) < $signed(rdata[0].pts);
    lt20 = $signed(rdata[2].pts) < $signed(rdata[0].pts);
    lt21 = $signed(rdata[2].pts) < $signed(rdata[1].pts);
    win[0] = nonempty[0] && (!nonempty[1] || !lt10) && (!nonempty[2] || !lt20);
    win[1] = nonempty[1] && (!nonempty[0] || lt10) && (!nonempty[2] || !lt21);
    win[2] = nonempty[2] && (!nonempty[0] || lt20) && (!nonempty[1] || lt21);
    any_ne = nonempty[0] || nonempty[1] || nonempty[2];
    if (win[0]) begin
      best_q     = 2'(tsqm_pkg::MEDIA_VIDEO);
      best_entry = rdata[0];
    end else if (win[1]) begin
      best_q     = 2'(tsqm_pkg::MEDIA_AUDIO);
      best_entry = rdata[1];
    end else begin
      best_q     = 2'(tsqm_pkg::MEDIA_META);
      best_entry = rdata[2];
    end
  end

  assign deq_commit = cmd.commit && (kind_r == tsqm_pkg::KIND_DEQ);
  assign do_push = cmd.commit && (kind_r == tsqm_pkg::KIND_ENQ) &&
                   (enq_status == tsqm_pkg::ST_ACCEPTED);
  assign do_pop  = deq_commit && any_ne;

  assign stat.out_free = !out_valid_r || out_ready;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_en_r    <= 1'b1;
      audio_en_r    <= 1'b1;
      meta_en_r     <= 1'b0;
      video_limit_r <= tsqm_pkg::VIDEO_LIMIT_RESET;
    end else if (cfg_we) begin
      case (tsqm_pkg::cfg_idx_t'(cfg_index))
        tsqm_pkg::CFG_VIDEO_EN:    video_en_r    <= cfg_data[0];
        tsqm_pkg::CFG_AUDIO_EN:    audio_en_r    <= cfg_data[0];
        tsqm_pkg::CFG_META_EN:     meta_en_r     <= cfg_data[0];
        tsqm_pkg::CFG_VIDEO_LIMIT: video_limit_r <= cfg_data;
        default:                   video_limit_r <= video_limit_r;
      endcase
    end
  end

  // held transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= tsqm_pkg::kind_t'(in_kind);
      media_r <= tsqm_pkg::media_t'(in_media_type);
      pts_r   <= in_pts;
      tag_r   <= tsqm_pkg::tag_t'(in_frame_tag);
    end
  end

  // pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < tsqm_pkg::NUM_Q; q++) begin
        rd_ptr_r[q] <= '0;
        wr_ptr_r[q] <= '0;
        cnt_r[q]    <= '0;
      end
    end else begin
      for (int q = 0; q < tsqm_pkg::NUM_Q; q++) begin
        if (ram_we[q]) begin
          wr_ptr_r[q] <= (wr_ptr_r[q] == tsqm_pkg::PTR_LAST) ? '0 : wr_ptr_r[q] + 1'b1;
          cnt_r[q]    <= cnt_r[q] + 1'b1;
        end else if (do_pop && (best_q == 2'(q))) begin
          rd_ptr_r[q] <= (rd_ptr_r[q] == tsqm_pkg::PTR_LAST) ? '0 : rd_ptr_r[q] + 1'b1;
          cnt_r[q]    <= cnt_r[q] - 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (kind_r == tsqm_pkg::KIND_ENQ) begin
        out_status_r <= enq_status;
        out_media_r  <= '0;
        out_pts_r    <= '0;
        out_tag_r    <= '0;
      end else if (any_ne) begin
        out_status_r <= tsqm_pkg::ST_DEQUEUED;
        out_media_r  <= best_q;
        out_pts_r    <= best_entry.pts;
        out_tag_r    <= tsqm_pkg::FRAME_TAG_W'(best_entry.tag);
      end else begin
        out_status_r <= tsqm_pkg::ST_EMPTY;
        out_media_r  <= '0;
        out_pts_r    <= '0;
        out_tag_r    <= '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_media  = out_media_r;
  assign out_pts    = out_pts_r;
  assign out_tag    = out_tag_r;

  // read data only settles on the execute cycle, so the winner check waits for it
  `TSQM_ASSERT_IMP(a_cnt0_bound, 1'b1, cnt_r[0] <= tsqm_pkg::CNT_FULL)
  `TSQM_ASSERT_IMP(a_cnt1_bound, 1'b1, cnt_r[1] <= tsqm_pkg::CNT_FULL)
  `TSQM_ASSERT_IMP(a_cnt2_bound, 1'b1, cnt_r[2] <= tsqm_pkg::CNT_FULL)
  `TSQM_ASSERT_IMP(a_one_winner, deq_commit && any_ne, $onehot({win[2], win[1], win[0]}))
  `TSQM_ASSERT_NXT(a_empty, deq_commit && !any_ne, out_valid_r && out_status_r == tsqm_pkg::ST_EMPTY)

endmodule

`default_nettype wire

[rtl/timestamp_ordered_three_queue_merge.sv]
// top level of the timestamp ordered three queue merge
//
// Three frame FIFOs (video, audio, metadata) of 256 entries each, every
// entry a 64-bit signed timestamp and a frame tag. An enqueue transaction
// (in_kind 0) stores into the queue of in_media_type when that stream is
// enabled and there is room; a video enqueue is also dropped when the video
// count is already above video_limit. A dequeue transaction (in_kind 1) pops
// the front with the smallest timestamp, ties going video, audio, metadata,
// or reports empty. Every transaction gives exactly one result. Sequence:
// an accepted transaction is first captured into the held registers and
// then executed against the registered read data of the queue rams;
// execution waits while the output register still holds an untaken
// result, and no new transaction is accepted until the held one has
// executed. No clearing pass after reset: queue read data is only used
// where it has been written. Config writes belong in idle periods.
`default_nettype none

module timestamp_ordered_three_queue_merge (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [tsqm_pkg::CFG_W-1:0]        cfg_data,
  // input transactions
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              in_kind,
  input  wire logic [1:0]                        in_media_type,
  input  wire logic signed [tsqm_pkg::PTS_W-1:0] in_pts,
  input  wire logic [tsqm_pkg::FRAME_TAG_W-1:0]  in_frame_tag,
  // result transactions
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [2:0]                        out_status,
  output      logic [1:0]                        out_media,
  output      logic signed [tsqm_pkg::PTS_W-1:0] out_pts,
  output      logic [tsqm_pkg::FRAME_TAG_W-1:0]  out_tag
);

  // command and status between controller and datapath
  tsqm_pkg::ctrl_cmd_t cmd;
  tsqm_pkg::dp_stat_t  stat;

  // sequencer: capture, then execute once the result slot is free
  tsqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queues, front compare, config and result register
  tsqm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_kind),
    .in_media_type (in_media_type),
    .in_pts        (in_pts),
    .in_frame_tag  (in_frame_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_media     (out_media),
    .out_pts       (out_pts),
    .out_tag       (out_tag)
  );

endmodule

`default_nettype wire
